// ===== rtl/tlbe_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbe_pkg
// shared sizes, types and helpers of the toroidal label boundary edge block
// ----------------------------------------------------------------------------
package tlbe_pkg;

	localparam int MAX_ROWS   = 1024;
	localparam int MAX_COLS   = 1024;
	localparam int LABEL_BITS = 16;

	// config registers and coordinates are 11 bits wide
	localparam int CFG_W     = 11;
	localparam int COORD_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int POS_W = $clog2(MAX_COLS);

	// job queue between front and back
	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT  = 1'b0,
		REG_ROW_LENGTH = 1'b1
	} reg_index_t;

	// one-hot edge codes, in emission order
	localparam int EDGE_KINDS = 4;
	typedef logic [EDGE_KINDS-1:0] edge_mask_t;
	localparam edge_mask_t EDGE_LEFT  = 4'b0001;
	localparam edge_mask_t EDGE_WRAP  = 4'b0010;
	localparam edge_mask_t EDGE_ABOVE = 4'b0100;
	localparam edge_mask_t EDGE_TOP   = 4'b1000;

	typedef logic [LABEL_BITS-1:0] label_t;

	// one classified cell waiting for the back end
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [CFG_W-1:0] rows;
		label_t           own;
		label_t           left;
		label_t           start;
		label_t           above;
		label_t           top;
		edge_mask_t       mask;
	} job_t;

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] maxv);
		logic [CFG_W-1:0] r;
		if (v < CFG_W'(2)) r = CFG_W'(2);
		else if (v > maxv) r = maxv;
		else r = v;
		return r;
	endfunction

endpackage

// ===== rtl/tlbe_ram.sv =====
// ----------------------------------------------------------------------------
// tlbe_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tlbe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tlbe_front.sv =====
// ----------------------------------------------------------------------------
// tlbe_front
// accepts cells, tracks the scan position and classifies the four neighbors
// ----------------------------------------------------------------------------
module tlbe_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  tlbe_pkg::label_t                group_label,
	input  logic                            cfg_write,
	input  logic [tlbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlbe_pkg::CFG_W-1:0]      cfg_data,
	input  logic [tlbe_pkg::JOB_CNT_W-1:0]  job_count,
	output logic                            job_push,
	output tlbe_pkg::job_t                  job
);
	import tlbe_pkg::*;

	logic [CFG_W-1:0] row_count_q, row_length_q;
	logic [ROW_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	label_t           left_q, start_q;

	logic             acc;
	logic [CFG_W-1:0] rows, cols, col_inc, row_inc;
	logic             col_wrap, row_wrap;
	label_t           prev_rd, top_rd;

	logic             valid_s1, left_hit_s1, wrap_hit_s1, above_en_s1, top_en_s1;
	logic [ROW_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;
	logic [CFG_W-1:0] rows_s1;
	label_t           cell_s1, left_s1, start_s1;

	logic [JOB_CNT_W:0] occupancy;

	// a cell in flight always finds a queue slot
	assign occupancy = {1'b0, job_count} + (JOB_CNT_W + 1)'(valid_s1);
	assign full      = occupancy >= (JOB_CNT_W + 1)'(JOB_DEPTH);
	assign acc       = push && !full;

	assign rows     = clamp_size(row_count_q, CFG_W'(MAX_ROWS));
	assign cols     = clamp_size(row_length_q, CFG_W'(MAX_COLS));
	assign col_inc  = CFG_W'(col_q) + CFG_W'(1);
	assign row_inc  = CFG_W'(row_q) + CFG_W'(1);
	assign col_wrap = col_inc >= cols;
	assign row_wrap = row_inc >= rows;

	tlbe_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_COLS)) u_prev_row (
		.clk   (clk),
		.we    (acc),
		.waddr (col_q),
		.wdata (group_label),
		.raddr (col_q),
		.rdata (prev_rd)
	);

	tlbe_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_COLS)) u_top_row (
		.clk   (clk),
		.we    (acc && (row_q == '0)),
		.waddr (col_q),
		.wdata (group_label),
		.raddr (col_q),
		.rdata (top_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= CFG_W'(MAX_ROWS);
			row_length_q <= CFG_W'(MAX_COLS);
			row_q        <= '0;
			col_q        <= '0;
			left_q       <= '0;
			start_q      <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ROW_COUNT:  row_count_q  <= cfg_data;
					REG_ROW_LENGTH: row_length_q <= cfg_data;
					default: ;
				endcase
			end
			valid_s1 <= acc;
			if (acc) begin
				left_q <= group_label;
				if (col_q == '0) begin
					start_q <= group_label;
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[POS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			row_s1      <= row_q;
			col_s1      <= col_q;
			rows_s1     <= rows;
			cell_s1     <= group_label;
			left_s1     <= left_q;
			start_s1    <= start_q;
			left_hit_s1 <= (col_q != '0) && (left_q != group_label);
			wrap_hit_s1 <= (col_inc == cols) && (start_q != group_label);
			above_en_s1 <= row_q != '0;
			top_en_s1   <= row_inc == rows;
		end
	end

	// store reads land here, in the cycle after the accept
	always_comb begin
		job.row   = row_s1;
		job.col   = col_s1;
		job.rows  = rows_s1;
		job.own   = cell_s1;
		job.left  = left_s1;
		job.start = start_s1;
		job.above = prev_rd;
		job.top   = top_rd;
		job.mask  = '0;
		if (left_hit_s1) job.mask = job.mask | EDGE_LEFT;
		if (wrap_hit_s1) job.mask = job.mask | EDGE_WRAP;
		if (above_en_s1 && (prev_rd != cell_s1)) job.mask = job.mask | EDGE_ABOVE;
		if (top_en_s1 && (top_rd != cell_s1)) job.mask = job.mask | EDGE_TOP;
	end

	// cells with no boundary never enter the queue
	assign job_push = valid_s1 && (job.mask != '0);

endmodule

// ===== rtl/tlbe_job_queue.sv =====
// ----------------------------------------------------------------------------
// tlbe_job_queue
// short fifo of classified cells between front and back
// ----------------------------------------------------------------------------
module tlbe_job_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  tlbe_pkg::job_t                 job_in,
	input  logic                           pop,
	output tlbe_pkg::job_t                 head,
	output logic                           head_valid,
	output logic [tlbe_pkg::JOB_CNT_W-1:0] count
);
	import tlbe_pkg::*;

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOB_CNT_W-1:0] count_q;
	logic                 do_pop;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign count      = count_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
			if (push && !do_pop) count_q <= count_q + JOB_CNT_W'(1);
			else if (do_pop && !push) count_q <= count_q - JOB_CNT_W'(1);
		end
	end

endmodule

// ===== rtl/tlbe_back.sv =====
// ----------------------------------------------------------------------------
// tlbe_back
// expands one queued cell into its edges, one edge per cycle while the output is taken
// ----------------------------------------------------------------------------
module tlbe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlbe_pkg::job_t               job,
	input  logic                         job_valid,
	output logic                         job_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [tlbe_pkg::COORD_W-1:0] start_row,
	output logic [tlbe_pkg::COORD_W-1:0] start_col,
	output logic [tlbe_pkg::COORD_W-1:0] end_row,
	output logic [tlbe_pkg::COORD_W-1:0] end_col,
	output tlbe_pkg::label_t             first_group,
	output tlbe_pkg::label_t             second_group,
	output logic                         last_edge
);
	import tlbe_pkg::*;

	edge_mask_t         done_q, pending, pick, rest;
	logic               out_valid_q, emit;
	logic [COORD_W-1:0] row_c, col_c, row_n, col_n;
	logic [COORD_W-1:0] sr, sc, er, ec;
	label_t             fg;

	assign pending = job.mask & ~done_q;
	assign pick    = pending & (~pending + edge_mask_t'(1));
	assign rest    = pending & ~pick;
	assign emit    = job_valid && (!out_valid_q || pop);
	assign job_pop = emit && (rest == '0);
	assign empty   = !out_valid_q;

	assign row_c = COORD_W'(job.row);
	assign col_c = COORD_W'(job.col);
	assign row_n = row_c + COORD_W'(1);
	assign col_n = col_c + COORD_W'(1);

	always_comb begin
		sr = row_c;
		sc = col_c;
		er = row_n;
		ec = col_c;
		fg = job.left;
		case (pick)
			EDGE_LEFT: ;
			EDGE_WRAP: begin
				sc = '0;
				ec = '0;
				fg = job.start;
			end
			EDGE_ABOVE: begin
				er = row_c;
				ec = col_n;
				fg = job.above;
			end
			EDGE_TOP: begin
				sr = job.rows;
				er = job.rows;
				ec = col_n;
				fg = job.top;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				done_q      <= (rest == '0) ? '0 : (done_q | pick);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			start_row    <= sr;
			start_col    <= sc;
			end_row      <= er;
			end_col      <= ec;
			first_group  <= fg;
			second_group <= job.own;
			last_edge    <= rest == '0;
		end
	end

endmodule

// ===== rtl/toroidal_label_boundary_edges_top.sv =====
// ----------------------------------------------------------------------------
// toroidal_label_boundary_edges_top
// boundary edge extractor for a wrapping group-label map
// ----------------------------------------------------------------------------
// cells of the label map are pushed in row-major order, one group_label per
// beat; each cell is checked against its left neighbor, the first cell of its
// row (on the last column), the cell above and the cell of row 0 (on the last
// row), and every differing pair yields one edge beat, the last one of a cell
// flagged by last_edge. edges leave one per cycle through a single result
// register while the receiver pops; a queue takes new cells before earlier
// edges are out, one cell per cycle inside a region while it has room. the
// first result passes the stage-1 registers, the job queue and the result
// register. the two row stores are plain rams that hold whatever was last
// written; there is no clearing pass after reset and the block takes cells
// right away. the user must write row_count and row_length only while idle
// (the block does not enforce it); they take effect from the next cell.
// ----------------------------------------------------------------------------
module toroidal_label_boundary_edges_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// cell input
	input  logic                           push,
	output logic                           full,
	input  logic [tlbe_pkg::LABEL_BITS-1:0] group_label,
	// edge output
	input  logic                           pop,
	output logic                           empty,
	output logic [tlbe_pkg::COORD_W-1:0]   start_row,
	output logic [tlbe_pkg::COORD_W-1:0]   start_col,
	output logic [tlbe_pkg::COORD_W-1:0]   end_row,
	output logic [tlbe_pkg::COORD_W-1:0]   end_col,
	output logic [tlbe_pkg::LABEL_BITS-1:0] first_group,
	output logic [tlbe_pkg::LABEL_BITS-1:0] second_group,
	output logic                           last_edge,
	// config writes
	input  logic                           cfg_write,
	input  logic [tlbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlbe_pkg::CFG_W-1:0]     cfg_data
);
	import tlbe_pkg::*;

	// front to queue
	job_t                 new_job;
	logic                 new_job_push;
	// queue to back
	job_t                 head_job;
	logic                 head_valid, head_pop;
	logic [JOB_CNT_W-1:0] job_count;

	// position tracking, store lookups and neighbor compares
	tlbe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.group_label (group_label),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.job_count   (job_count),
		.job_push    (new_job_push),
		.job         (new_job)
	);

	// decouples the cell rate from the edge rate
	tlbe_job_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (new_job_push),
		.job_in     (new_job),
		.pop        (head_pop),
		.head       (head_job),
		.head_valid (head_valid),
		.count      (job_count)
	);

	// edge generation and the result register
	tlbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (head_job),
		.job_valid    (head_valid),
		.job_pop      (head_pop),
		.pop          (pop),
		.empty        (empty),
		.start_row    (start_row),
		.start_col    (start_col),
		.end_row      (end_row),
		.end_col      (end_col),
		.first_group  (first_group),
		.second_group (second_group),
		.last_edge    (last_edge)
	);

endmodule

// ===== rtl/tlbe_checker.sv =====
// ----------------------------------------------------------------------------
// tlbe_checker
// port-level checks of the boundary edge block
// ----------------------------------------------------------------------------
module tlbe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            full,
	input logic                            pop,
	input logic                            empty,
	input logic [tlbe_pkg::COORD_W-1:0]    start_row,
	input logic [tlbe_pkg::COORD_W-1:0]    start_col,
	input logic [tlbe_pkg::COORD_W-1:0]    end_row,
	input logic [tlbe_pkg::COORD_W-1:0]    end_col,
	input logic [tlbe_pkg::LABEL_BITS-1:0] first_group,
	input logic [tlbe_pkg::LABEL_BITS-1:0] second_group,
	input logic                            last_edge
);
	import tlbe_pkg::*;

	// a waiting edge holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(start_row) && $stable(start_col)
			&& $stable(end_row) && $stable(end_col) && $stable(first_group)
			&& $stable(second_group) && $stable(last_edge)))
		else $error("edge beat changed while stalled");

	// an edge only separates two different groups
	a_differ: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (first_group != second_group))
		else $error("edge between equal groups");

	// every segment is one unit long, vertical or horizontal
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (((start_col == end_col) && (end_row == start_row + COORD_W'(1)))
			|| ((start_row == end_row) && (end_col == start_col + COORD_W'(1)))))
		else $error("segment is not a unit step");

	// reset drops any pending edge and opens the input
	a_reset: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("outputs not cleared by reset");

endmodule

bind toroidal_label_boundary_edges_top tlbe_checker u_checker (.*);

// ===== verif/toroidal_label_boundary_edges_top_test.sv =====
// ----------------------------------------------------------------------------
// toroidal_label_boundary_edges_top_test
// self-checking bench for the wrapping label map boundary edge extractor
// ----------------------------------------------------------------------------
// cells are pushed in row-major order and every edge beat that comes out is
// checked against a cycle-free model of the map walk kept in a scoreboard
// class. a short directed part walks two tiny maps (one-cell islands, cells
// with no edge, all-zero and all-one labels), then one 64-column row and a
// bit of the next with a mid-map shrink, then random phases with random map
// sizes (out of range ones too) and random labels drawn mostly from a small
// set so that regions form. both sides idle at random and once the receiver
// holds off long enough for the block to fill up and stall the input.
// ----------------------------------------------------------------------------
module toroidal_label_boundary_edges_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlbe_pkg::*;

	localparam int HOLD_CYCLES = 300;

	// one edge beat, laid out in port order
	typedef struct packed {
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] end_row;
		logic [COORD_W-1:0] end_col;
		label_t             first_group;
		label_t             second_group;
		logic               last_edge;
	} edge_beat_t;

	// walks the map alongside the block and holds the edge beats still owed
	class edge_scoreboard;
		logic [CFG_W-1:0] row_count_reg;
		logic [CFG_W-1:0] row_length_reg;
		label_t           prev_row [MAX_COLS];
		label_t           top_row [MAX_COLS];
		label_t           left_label;
		label_t           row_first_label;
		int unsigned      row_pos;
		int unsigned      col_pos;
		// row 0 is always written from column 0 up, so written entries form a prefix
		int unsigned      written_width;
		edge_beat_t       owed_edges[$];
		int               mismatches;

		function new();
			row_count_reg   = CFG_W'(MAX_ROWS);
			row_length_reg  = CFG_W'(MAX_COLS);
			left_label      = '0;
			row_first_label = '0;
			row_pos         = 0;
			col_pos         = 0;
			written_width   = 0;
			mismatches      = 0;
		endfunction

		function int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned maxv);
			if (v < 2) return 2;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function void set_reg(reg_index_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_ROW_COUNT: begin
					row_count_reg = v;
				end
				REG_ROW_LENGTH: begin
					row_length_reg = v;
				end
				default: begin
				end
			endcase
		endfunction

		function edge_beat_t make_beat(int unsigned r0, int unsigned c0, int unsigned r1,
				int unsigned c1, label_t g1, label_t g2);
			edge_beat_t b;
			b.start_row    = COORD_W'(r0);
			b.start_col    = COORD_W'(c0);
			b.end_row      = COORD_W'(r1);
			b.end_col      = COORD_W'(c1);
			b.first_group  = g1;
			b.second_group = g2;
			b.last_edge    = 1'b0;
			return b;
		endfunction

		function int pending();
			return owed_edges.size();
		endfunction

		function void note_cell(label_t lab);
			int unsigned rows, cols, r, c;
			edge_beat_t  beats[$];
			edge_beat_t  tail;
			rows = eff_size(row_count_reg, MAX_ROWS);
			cols = eff_size(row_length_reg, MAX_COLS);
			r = row_pos;
			c = col_pos;
			// left neighbor, first cell of the row, cell above, cell of row 0
			if (c > 0 && left_label != lab)
				beats = {beats, make_beat(r, c, r + 1, c, left_label, lab)};
			if (c == cols - 1 && row_first_label != lab)
				beats = {beats, make_beat(r, 0, r + 1, 0, row_first_label, lab)};
			if (r > 0 && prev_row[c] != lab)
				beats = {beats, make_beat(r, c, r, c + 1, prev_row[c], lab)};
			if (r == rows - 1 && top_row[c] != lab)
				beats = {beats, make_beat(rows, c, rows, c + 1, top_row[c], lab)};
			if (beats.size() > 0) begin
				tail = beats[beats.size() - 1];
				tail.last_edge = 1'b1;
				beats[beats.size() - 1] = tail;
			end
			foreach (beats[i])
				owed_edges = {owed_edges, beats[i]};

			prev_row[c] = lab;
			if (r == 0) begin
				top_row[c] = lab;
				if (c + 1 > written_width)
					written_width = c + 1;
			end
			if (c == 0)
				row_first_label = lab;
			left_label = lab;
			// positions wrap as soon as the next one reaches the current size
			if (c + 1 >= cols) begin
				col_pos = 0;
				row_pos = (r + 1 >= rows) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_edge(edge_beat_t got);
			edge_beat_t want;
			if (owed_edges.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: edge beat (%0d,%0d)-(%0d,%0d) %h/%h last %b, none owed",
						$time, got.start_row, got.start_col, got.end_row, got.end_col,
						got.first_group, got.second_group, got.last_edge);
				mismatches++;
				return;
			end
			want = owed_edges.pop_front();
			if (got.start_row !== want.start_row || got.start_col !== want.start_col ||
					got.end_row !== want.end_row || got.end_col !== want.end_col ||
					got.first_group !== want.first_group ||
					got.second_group !== want.second_group ||
					got.last_edge !== want.last_edge) begin
				if (mismatches < 10) begin
					$display("%0t: edge mismatch, expected (%0d,%0d)-(%0d,%0d) groups %h/%h last %b",
						$time, want.start_row, want.start_col, want.end_row, want.end_col,
						want.first_group, want.second_group, want.last_edge);
					$display("%0t:                   actual (%0d,%0d)-(%0d,%0d) groups %h/%h last %b",
						$time, got.start_row, got.start_col, got.end_row, got.end_col,
						got.first_group, got.second_group, got.last_edge);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	label_t               group_label;
	logic                 pop;
	logic                 empty;
	logic [COORD_W-1:0]   start_row;
	logic [COORD_W-1:0]   start_col;
	logic [COORD_W-1:0]   end_row;
	logic [COORD_W-1:0]   end_col;
	label_t               first_group;
	label_t               second_group;
	logic                 last_edge;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	edge_beat_t    seen_edge;
	edge_scoreboard sb = new();
	// set by the stimulus, cleared by the receiver once the long hold-off is over
	bit            hold_request = 1'b0;

	toroidal_label_boundary_edges_top dut (.*);

	assign seen_edge = {start_row, start_col, end_row, end_col,
		first_group, second_group, last_edge};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// mostly no gap, sometimes a few cycles, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	// both handshakes are sampled here, at the rising edge, in one process;
	// the cell beat is noted before the edge beat of the same cycle is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_cell(group_label);
			if (pop && !empty)
				sb.check_edge(seen_edge);
		end
	end

	// receiver: random stalls, calm stretches, and one long hold-off on request
	initial begin
		int stall;
		int calm_left;
		stall = 0;
		calm_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					stall = pick_gap();
					if ($urandom_range(0, 199) == 0)
						calm_left = $urandom_range(50, 200);
				end
			end
		end
	end

	// both registers, one after the other, with the write enable held high
	task automatic write_config(input logic [CFG_W-1:0] rows_raw,
			input logic [CFG_W-1:0] cols_raw);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_data  <= rows_raw;
		@(posedge clk);
		sb.set_reg(REG_ROW_COUNT, rows_raw);
		@(negedge clk);
		cfg_index <= REG_ROW_LENGTH;
		cfg_data  <= cols_raw;
		@(posedge clk);
		sb.set_reg(REG_ROW_LENGTH, cols_raw);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// push stays high across back-to-back beats, it only drops for a gap
	task automatic send_cells(input label_t cells[$], input bit use_gaps);
		int gap;
		foreach (cells[i]) begin
			gap = use_gaps ? pick_gap() : 0;
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			push        <= 1'b1;
			group_label <= cells[i];
			do @(posedge clk); while (full);
		end
		@(negedge clk);
		push <= 1'b0;
	endtask

	// wait for every owed beat, then let cells with no edge run out
	task automatic drain(input int settle);
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		label_t           cells[$];
		label_t           hue[3];
		label_t           run_label;
		logic [CFG_W-1:0] rows_raw;
		logic [CFG_W-1:0] cols_raw;
		int               pick;
		int               n;
		int               bias;
		int               phase;
		int               random_items;
		bit               gaps;

		arst_n      = 1'b0;
		push        = 1'b0;
		group_label = '0;
		cfg_write   = 1'b0;
		cfg_index   = REG_ROW_COUNT;
		cfg_data    = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// row count below range acts as 2, three columns
		write_config(11'd0, 11'd3);
		// first map: last cell of row 1 differs from all four neighbors
		cells = '{16'h0000, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h0000, 16'h5555};
		send_cells(cells, 1'b1);
		// second map: flat region, cells with no edge, then a corner cell unlike all four neighbors
		cells = '{16'hAAAA, 16'hAAAA, 16'hAAAA,
			16'hAAAA, 16'hAAAA, 16'h1234};
		send_cells(cells, 1'b1);

		// 64-column row, then a short stretch of row 1
		drain(8);
		write_config(11'd2, 11'd64);
		cells.delete();
		run_label = label_t'($urandom);
		for (int i = 0; i < 64 + 40; i++) begin
			if ($urandom_range(0, 19) == 0)
				run_label = label_t'($urandom);
			cells = {cells, run_label};
		end
		send_cells(cells, 1'b1);

		// shrink mid-row: column 40 is past the new size, so the walk wraps
		// right after the next cell; row count above range acts as the maximum
		drain(8);
		write_config(11'h7FF, 11'd2);
		cells.delete();
		for (int i = 0; i < 8; i++)
			cells = {cells, label_t'($urandom_range(0, 3))};
		send_cells(cells, 1'b0);

		// random phases
		phase = 0;
		random_items = 0;
		while (random_items < 236) begin
			drain(8);
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) rows_raw = $urandom_range(0, 1);
				else if (pick < 14) rows_raw = $urandom_range(1025, 2047);
				else if (pick < 18) rows_raw = 11'd1024;
				else rows_raw = $urandom_range(2, 6);
				pick = $urandom_range(0, 99);
				if (pick < 8) cols_raw = $urandom_range(0, 1);
				else if (pick < 18) cols_raw = $urandom_range(9, 40);
				else cols_raw = $urandom_range(2, 8);
				// below row 0 a wider row would read columns never written
				if (sb.row_pos != 0 && sb.eff_size(cols_raw, MAX_COLS) > sb.written_width)
					cols_raw = $urandom_range(2, sb.written_width < 8 ? sb.written_width : 8);
				write_config(rows_raw, cols_raw);
			end

			foreach (hue[i])
				hue[i] = label_t'($urandom);
			bias = 85;
			gaps = ($urandom_range(0, 3) != 0);
			n = $urandom_range(15, 45);
			if (phase == 2) begin
				// receiver holds off while the sender keeps pushing edge-heavy cells
				hold_request = 1'b1;
				gaps = 1'b0;
				bias = 0;
				n = 45;
			end
			cells.delete();
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < bias)
					cells = {cells, hue[$urandom_range(0, 2)]};
				else
					cells = {cells, label_t'($urandom)};
			end
			send_cells(cells, gaps);
			random_items += n;
			phase++;
		end

		drain(20);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tlbe_pkg.sv
rtl/tlbe_ram.sv
rtl/tlbe_front.sv
rtl/tlbe_job_queue.sv
rtl/tlbe_back.sv
rtl/toroidal_label_boundary_edges_top.sv
rtl/tlbe_checker.sv
verif/toroidal_label_boundary_edges_top_test.sv
